@@ design/tcr_pkg.sv @@
package tcr_pkg;

  localparam int LIN_FRAC_BITS = 12;
  localparam int LIN_W         = LIN_FRAC_BITS + 1;
  localparam int BYTE_W        = 8;
  localparam int AFF_W         = 16;
  localparam int AFF_FRAC_BITS = 12;
  localparam int MUL_A_W       = (LIN_W > BYTE_W) ? LIN_W : BYTE_W;
  localparam int PROD_W        = MUL_A_W + AFF_W + 1;
  localparam int SUM_W         = PROD_W + 1;
  localparam int SEARCH_STEPS  = BYTE_W;
  localparam int LANE_STAGES   = 4 + SEARCH_STEPS;
  localparam int NUM_CHAN      = 4;
  localparam int ALPHA_CHAN    = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [CFG_DATA_W-1:0] AFFINE_IDENTITY = 32'h1000_0000;

  localparam logic signed [SUM_W-1:0] ENC_ONE  = SUM_W'(255 * (1 << AFF_FRAC_BITS));
  localparam logic signed [SUM_W-1:0] LIN_ONE  =
    SUM_W'(64'd1 << (LIN_FRAC_BITS + AFF_FRAC_BITS));
  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1 << (AFF_FRAC_BITS - 1));
  localparam logic [LIN_W-1:0]        LIN_MAX  = LIN_W'(1 << LIN_FRAC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_PRESENT,
    CFG_FILL_BYTES,
    CFG_SRGB_MODE,
    CFG_AFFINE_RED,
    CFG_AFFINE_GREEN,
    CFG_AFFINE_BLUE,
    CFG_AFFINE_ALPHA
  } tcr_cfg_idx_t;

  typedef logic [255:0][LIN_W-1:0] lin_tab_t;

  typedef struct packed {
    logic [LANE_STAGES-1:0] load;
    logic                   tail_valid;
  } tcr_pipe_t;

  typedef struct packed {
    logic                  present;
    logic                  srgb;
    logic [BYTE_W-1:0]     fill;
    logic [CFG_DATA_W-1:0] affine;
  } tcr_lane_cfg_t;

  // The functions below only build the constant tables during elaboration.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [127:0] rem;
    logic [127:0] dsh;
    logic [63:0]  q;
    rem = {64'd0, num};
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      dsh = {64'd0, den} << i;
      if (rem >= dsh) begin
        rem  = rem - dsh;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Newton iteration for the fifth root in Q30, 48 steps from 1.0. Once the
  // sequence settles on a value or a pair of values, the rest is skipped.
  function automatic logic [63:0] fifth_root_q30(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] r_prev;
    logic [63:0] r_next;
    logic [63:0] r2;
    logic [63:0] r4;
    logic [63:0] q;
    logic        done;
    r      = 64'd1 << 30;
    r_prev = '0;
    done   = 1'b0;
    for (int it = 0; it < 48; it++) begin
      if (!done) begin
        r2 = (r * r) >> 30;
        r4 = (r2 * r2) >> 30;
        if (r4 == 64'd0) begin
          done = 1'b1;
        end else begin
          q      = udiv64(x << 30, r4);
          r_next = (64'd4 * r + q) / 64'd5;
          if (r_next == r) begin
            done = 1'b1;
          end else if (r_next == r_prev) begin
            if (((47 - it) % 2) == 0) begin
              r = r_next;
            end
            done = 1'b1;
          end else begin
            r_prev = r;
            r      = r_next;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] lin16_of(input logic [31:0] n);
    logic [63:0] a30;
    logic [63:0] a2;
    logic [63:0] r;
    logic [63:0] l30;
    if (n <= 32'd20) begin
      return 32'((64'(n) * 64'd6553600 + 64'd329460) / 64'd658920);
    end
    a30 = ((64'(1000 * n + 28050) << 30) + 64'd269025) / 64'd538050;
    a2  = (a30 * a30 + (64'd1 << 29)) >> 30;
    r   = fifth_root_q30(a2);
    l30 = (a2 * r + (64'd1 << 29)) >> 30;
    return 32'((l30 + 64'd8192) >> 14);
  endfunction

  function automatic logic [31:0] to_lfb(input logic [31:0] x16);
    int sh;
    sh = 16 - LIN_FRAC_BITS;
    if (sh == 0) begin
      return x16;
    end
    return (x16 + (32'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic lin_tab_t build_dec();
    lin_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = LIN_W'(to_lfb(lin16_of(32'(2 * i))));
    end
    return t;
  endfunction

  // Entry c holds the threshold that output code c must reach; entry 0 is
  // always met.
  function automatic lin_tab_t build_thr();
    lin_tab_t    t;
    logic [31:0] v;
    t[0] = '0;
    for (int k = 0; k < 255; k++) begin
      v = to_lfb(lin16_of(32'(2 * k + 1)));
      if (v < 32'd1) begin
        v = 32'd1;
      end
      t[k + 1] = LIN_W'(v);
    end
    return t;
  endfunction

  localparam lin_tab_t DEC_TAB = build_dec();
  localparam lin_tab_t THR_TAB = build_thr();

endpackage

@@ design/tcr_pipe_ctrl.sv @@
module tcr_pipe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               take,
  output logic               in_stall,
  output tcr_pkg::tcr_pipe_t pipe
);

  localparam int L = tcr_pkg::LANE_STAGES;

  logic [L-1:0] valid_r;
  logic [L-1:0] ready;
  logic [L-1:0] prev_valid;

  // A stage may load when there is a bubble at or after it, or when the
  // output register takes a word this cycle.
  always_comb begin
    prev_valid[0] = in_valid;
    for (int i = 1; i < L; i++) begin
      prev_valid[i] = valid_r[i-1];
    end
    for (int i = 0; i < L; i++) begin
      ready[i] = take;
      for (int k = i; k < L; k++) begin
        if (!valid_r[k]) begin
          ready[i] = 1'b1;
        end
      end
    end
  end

  assign pipe.load       = ready & prev_valid;
  assign pipe.tail_valid = valid_r[L-1];
  assign in_stall        = !ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int i = 0; i < L; i++) begin
        if (ready[i]) begin
          valid_r[i] <= prev_valid[i];
        end
      end
    end
  end

endmodule

@@ design/tcr_lane.sv @@
module tcr_lane (
  input  logic                             clk,
  input  tcr_pkg::tcr_pipe_t               pipe,
  input  tcr_pkg::tcr_lane_cfg_t           cfg,
  input  logic [tcr_pkg::BYTE_W-1:0]       src_byte,
  output logic [tcr_pkg::BYTE_W-1:0]       res_byte
);

  localparam int BW = tcr_pkg::BYTE_W;
  localparam int LW = tcr_pkg::LIN_W;
  localparam int AW = tcr_pkg::AFF_W;
  localparam int MW = tcr_pkg::MUL_A_W;
  localparam int PW = tcr_pkg::PROD_W;
  localparam int SW = tcr_pkg::SUM_W;
  localparam int NS = tcr_pkg::SEARCH_STEPS;

  typedef enum logic [1:0] {
    MODE_FILL,
    MODE_PASS,
    MODE_ENC,
    MODE_SRGB
  } mode_t;

  logic signed [AW-1:0] scale;
  logic signed [AW-1:0] bias;

  assign scale = cfg.affine[2*AW-1:AW];
  assign bias  = cfg.affine[AW-1:0];

  // Stage 0: pick the path and look up the linear value.
  mode_t             mode_nxt;
  mode_t             mode0_r;
  logic [BW-1:0]     byte0_r;
  logic [LW-1:0]     dec0_r;

  always_comb begin
    if (!cfg.present) begin
      mode_nxt = MODE_FILL;
    end else if (cfg.affine == tcr_pkg::AFFINE_IDENTITY) begin
      mode_nxt = MODE_PASS;
    end else if (cfg.srgb) begin
      mode_nxt = MODE_SRGB;
    end else begin
      mode_nxt = MODE_ENC;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe.load[0]) begin
      byte0_r <= src_byte;
      dec0_r  <= tcr_pkg::DEC_TAB[src_byte];
      mode0_r <= mode_nxt;
    end
  end

  // Stage 1: one signed multiply by the scale.
  logic [MW-1:0]        mul_a;
  logic signed [MW:0]   mul_op;
  logic signed [PW-1:0] prod_nxt;
  logic signed [PW-1:0] prod1_r;
  mode_t                mode1_r;
  logic [BW-1:0]        byte1_r;

  always_comb begin
    mul_a    = (mode0_r == MODE_SRGB) ? MW'(dec0_r) : MW'(byte0_r);
    mul_op   = {1'b0, mul_a};
    prod_nxt = PW'(mul_op) * PW'(scale);
  end

  always_ff @(posedge clk) begin
    if (pipe.load[1]) begin
      prod1_r <= prod_nxt;
      mode1_r <= mode0_r;
      byte1_r <= byte0_r;
    end
  end

  // Stage 2: add the bias in the units of the product. On the byte path the
  // byte stands for byte/255, so the bias is scaled by 255.
  logic signed [SW-1:0] bias_ext;
  logic signed [SW-1:0] bterm;
  logic signed [SW-1:0] sum2_r;
  mode_t                mode2_r;
  logic [BW-1:0]        byte2_r;

  always_comb begin
    bias_ext = SW'(bias);
    if (mode1_r == MODE_SRGB) begin
      bterm = bias_ext <<< tcr_pkg::LIN_FRAC_BITS;
    end else begin
      bterm = (bias_ext <<< BW) - bias_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe.load[2]) begin
      sum2_r  <= SW'(prod1_r) + bterm;
      mode2_r <= mode1_r;
      byte2_r <= byte1_r;
    end
  end

  // Stage 3: clamp and round half up.
  logic signed [SW-1:0] rnd;
  logic signed [SW-1:0] rnd_q;
  logic                 le_zero;
  logic [BW-1:0]        enc_byte;
  logic [LW-1:0]        m_nxt;
  logic [BW-1:0]        res3;

  always_comb begin
    rnd     = sum2_r + tcr_pkg::RND_HALF;
    rnd_q   = rnd >>> tcr_pkg::AFF_FRAC_BITS;
    le_zero = sum2_r[SW-1] || (sum2_r == '0);
    if (le_zero) begin
      enc_byte = '0;
    end else if (sum2_r >= tcr_pkg::ENC_ONE) begin
      enc_byte = '1;
    end else begin
      enc_byte = rnd_q[BW-1:0];
    end
    if (le_zero) begin
      m_nxt = '0;
    end else if (sum2_r >= tcr_pkg::LIN_ONE) begin
      m_nxt = tcr_pkg::LIN_MAX;
    end else begin
      m_nxt = rnd_q[LW-1:0];
    end
    case (mode2_r)
      MODE_FILL: res3 = cfg.fill;
      MODE_PASS: res3 = byte2_r;
      MODE_ENC:  res3 = enc_byte;
      MODE_SRGB: res3 = '0;
      default:   res3 = '0;
    endcase
  end

  // Stages 4 and up: the output code is the number of encode thresholds at
  // or below the linear value. The thresholds rise with the code, so one
  // bit of the code is settled per stage, most significant first.
  logic [NS:0][BW-1:0]   res_r;
  logic [NS-1:0][LW-1:0] m_r;
  logic [NS-1:0]         srgb_r;
  logic [NS-1:0][BW-1:0] cand;
  logic [NS-1:0]         hit;

  always_comb begin
    for (int j = 0; j < NS; j++) begin
      cand[j] = res_r[j] | (BW'(1) << (NS - 1 - j));
      hit[j]  = srgb_r[j] && (tcr_pkg::THR_TAB[cand[j]] <= m_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (pipe.load[3]) begin
      res_r[0]  <= res3;
      m_r[0]    <= m_nxt;
      srgb_r[0] <= (mode2_r == MODE_SRGB);
    end
    for (int j = 0; j < NS; j++) begin
      if (pipe.load[4+j]) begin
        res_r[j+1] <= hit[j] ? cand[j] : res_r[j];
      end
    end
    for (int j = 0; j < NS - 1; j++) begin
      if (pipe.load[4+j]) begin
        m_r[j+1]    <= m_r[j];
        srgb_r[j+1] <= srgb_r[j];
      end
    end
  end

  assign res_byte = res_r[NS];

endmodule

@@ design/tcr_merge.sv @@
module tcr_merge (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  tcr_pkg::tcr_pipe_t                               pipe,
  input  logic [tcr_pkg::NUM_CHAN-1:0][tcr_pkg::BYTE_W-1:0] lane_res,
  input  logic                                             out_stall,
  output logic                                             take,
  output logic                                             texel_valid,
  output logic [tcr_pkg::NUM_CHAN-1:0][tcr_pkg::BYTE_W-1:0] texel
);

  logic                                              out_valid_r;
  logic [tcr_pkg::NUM_CHAN-1:0][tcr_pkg::BYTE_W-1:0] texel_r;

  // The output register is free when it is empty or its word leaves now.
  assign take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= pipe.tail_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && pipe.tail_valid) begin
      texel_r <= lane_res;
    end
  end

  assign texel_valid = out_valid_r;
  assign texel       = texel_r;

endmodule

@@ design/texel_channel_repack.sv @@
// Texel channel repacker. Each input word carries four source bytes, one per
// destination channel R, G, B, A; each output word carries the finished RGBA8
// texel. Both channels use valid and stall: a word moves on a rising edge
// where valid is high and stall is low.
// The four channels run in parallel lanes. Each lane reads its byte through
// the sRGB decode ROM, multiplies once by the Q4.12 scale, adds the bias,
// clamps and rounds, and then, in sRGB mode, finds the encoded code with an
// eight-stage search of the threshold ROM, one code bit per stage.
// A word passes the lane stages and the output register. Unless the receiver
// stalls, a new word can be accepted every cycle: one texel per clock.
// When the receiver stalls, the output word holds and the pipeline keeps
// accepting words until every stage is full; only then is in_stall raised.
// The configuration port writes one register per cycle with cfg_we high;
// write it only while no word is in flight. Synchronous reset clears the
// pipeline, makes all channels take their fill byte (zero) and sets every
// affine to identity.
module texel_channel_repack (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tcr_pkg::BYTE_W-1:0]       in_src_red,
  input  logic [tcr_pkg::BYTE_W-1:0]       in_src_green,
  input  logic [tcr_pkg::BYTE_W-1:0]       in_src_blue,
  input  logic [tcr_pkg::BYTE_W-1:0]       in_src_alpha,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tcr_pkg::BYTE_W-1:0]       out_red,
  output logic [tcr_pkg::BYTE_W-1:0]       out_green,
  output logic [tcr_pkg::BYTE_W-1:0]       out_blue,
  output logic [tcr_pkg::BYTE_W-1:0]       out_alpha,
  input  logic                             cfg_we,
  input  logic [tcr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int NC = tcr_pkg::NUM_CHAN;
  localparam int BW = tcr_pkg::BYTE_W;

  logic [NC-1:0]                           channel_present_r;
  logic [NC*BW-1:0]                        fill_bytes_r;
  logic                                    srgb_mode_r;
  logic [NC-1:0][tcr_pkg::CFG_DATA_W-1:0]  affine_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_present_r <= '0;
      fill_bytes_r      <= '0;
      srgb_mode_r       <= 1'b0;
      for (int c = 0; c < NC; c++) begin
        affine_r[c] <= tcr_pkg::AFFINE_IDENTITY;
      end
    end else if (cfg_we) begin
      case (tcr_pkg::tcr_cfg_idx_t'(cfg_index))
        tcr_pkg::CFG_CHANNEL_PRESENT: channel_present_r <= cfg_wdata[NC-1:0];
        tcr_pkg::CFG_FILL_BYTES:      fill_bytes_r      <= cfg_wdata[NC*BW-1:0];
        tcr_pkg::CFG_SRGB_MODE:       srgb_mode_r       <= cfg_wdata[0];
        tcr_pkg::CFG_AFFINE_RED:      affine_r[0]       <= cfg_wdata;
        tcr_pkg::CFG_AFFINE_GREEN:    affine_r[1]       <= cfg_wdata;
        tcr_pkg::CFG_AFFINE_BLUE:     affine_r[2]       <= cfg_wdata;
        tcr_pkg::CFG_AFFINE_ALPHA:    affine_r[3]       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Alpha always stays in encoded space.
  tcr_pkg::tcr_lane_cfg_t [NC-1:0] lane_cfg;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      lane_cfg[c].present = channel_present_r[c];
      lane_cfg[c].srgb    = srgb_mode_r && (c != tcr_pkg::ALPHA_CHAN);
      lane_cfg[c].fill    = fill_bytes_r[c*BW +: BW];
      lane_cfg[c].affine  = affine_r[c];
    end
  end

  logic [NC-1:0][BW-1:0] src_bytes;
  logic [NC-1:0][BW-1:0] lane_res;
  logic [NC-1:0][BW-1:0] texel;
  tcr_pkg::tcr_pipe_t    pipe;
  logic                  take;

  assign src_bytes = {in_src_alpha, in_src_blue, in_src_green, in_src_red};

  tcr_pipe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .take     (take),
    .in_stall (in_stall),
    .pipe     (pipe)
  );

  for (genvar c = 0; c < NC; c++) begin : g_lane
    tcr_lane u_lane (
      .clk      (clk),
      .pipe     (pipe),
      .cfg      (lane_cfg[c]),
      .src_byte (src_bytes[c]),
      .res_byte (lane_res[c])
    );
  end

  tcr_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .pipe        (pipe),
    .lane_res    (lane_res),
    .out_stall   (out_stall),
    .take        (take),
    .texel_valid (out_valid),
    .texel       (texel)
  );

  assign out_red   = texel[0];
  assign out_green = texel[1];
  assign out_blue  = texel[2];
  assign out_alpha = texel[3];

  // Input back-pressure only ever comes from a stalled, full output.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled output word");

  // Leaving reset, the block is empty and ready.
  assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> (!out_valid && !in_stall))
    else $error("pipeline not empty after reset");

endmodule

@@ sim/texel_channel_repack_test.sv @@
module texel_channel_repack_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 10;
  localparam int LATENCY      = 12;
  localparam int SETTLE       = LATENCY + 8;
  localparam int NUM_RANDOM   = 1300;
  localparam int IDX_W        = tcr_pkg::CFG_IDX_W;
  localparam logic [IDX_W-1:0] CFG_IDX_UNUSED = IDX_W'(tcr_pkg::CFG_AFFINE_ALPHA + 1);

  typedef logic [tcr_pkg::BYTE_W-1:0] byte_t;
  // Channel 0 is red, channel 3 is alpha.
  typedef logic [tcr_pkg::NUM_CHAN-1:0][tcr_pkg::BYTE_W-1:0] texel_t;

  typedef struct packed {
    logic [3:0]                          present;
    logic [31:0]                         fill;
    logic                                srgb;
    logic [tcr_pkg::NUM_CHAN-1:0][31:0]  affine;
  } repack_cfg_t;

  class texel_scoreboard;
    repack_cfg_t  cfg;
    int unsigned  decode_lut [256];
    int unsigned  thresh_lut [255];
    texel_t       pending [$];
    int unsigned  mismatches;
    int unsigned  checked;
    string        chan_name [tcr_pkg::NUM_CHAN] = '{"red", "green", "blue", "alpha"};

    function new();
      mismatches = 0;
      checked    = 0;
      build_luts();
      cfg.present = '0;
      cfg.fill    = '0;
      cfg.srgb    = 1'b0;
      for (int c = 0; c < tcr_pkg::NUM_CHAN; c++) begin
        cfg.affine[c] = tcr_pkg::AFFINE_IDENTITY;
      end
    endfunction

    // Newton iteration for x^(1/5) in Q30, up to 48 steps from 1.0; it stops early if r^4 is zero.
    function longint unsigned fifth_root(longint unsigned x);
      longint unsigned r, r2, r4, q;
      r = 64'd1 << 30;
      for (int it = 0; it < 48; it++) begin
        r2 = (r * r) >> 30;
        r4 = (r2 * r2) >> 30;
        if (r4 == 0) break;
        q = (x << 30) / r4;
        r = (64'd4 * r + q) / 64'd5;
      end
      return r;
    endfunction

    // sRGB-to-linear of n/510 in Q16.
    function int unsigned srgb_to_lin16(int unsigned n);
      longint unsigned nn, a30, a2, r, l30;
      nn = n;
      if (n <= 20) begin
        return int'((nn * 64'd6553600 + 64'd329460) / 64'd658920);
      end
      a30 = (((nn * 64'd1000 + 64'd28050) << 30) + 64'd269025) / 64'd538050;
      a2  = (a30 * a30 + (64'd1 << 29)) >> 30;
      r   = fifth_root(a2);
      l30 = (a2 * r + (64'd1 << 29)) >> 30;
      return int'((l30 + 64'd8192) >> 14);
    endfunction

    function int unsigned q16_to_lin(int unsigned x);
      int sh;
      sh = 16 - tcr_pkg::LIN_FRAC_BITS;
      if (sh == 0) return x;
      return (x + (32'd1 << (sh - 1))) >> sh;
    endfunction

    function void build_luts();
      int unsigned t;
      for (int i = 0; i < 256; i++) begin
        decode_lut[i] = q16_to_lin(srgb_to_lin16(2 * i));
      end
      for (int k = 0; k < 255; k++) begin
        t = q16_to_lin(srgb_to_lin16(2 * k + 1));
        thresh_lut[k] = (t < 1) ? 1 : t;
      end
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        tcr_pkg::CFG_CHANNEL_PRESENT: cfg.present = data[3:0];
        tcr_pkg::CFG_FILL_BYTES:      cfg.fill    = data;
        tcr_pkg::CFG_SRGB_MODE:       cfg.srgb    = data[0];
        tcr_pkg::CFG_AFFINE_RED, tcr_pkg::CFG_AFFINE_GREEN, tcr_pkg::CFG_AFFINE_BLUE,
        tcr_pkg::CFG_AFFINE_ALPHA:
          cfg.affine[idx - tcr_pkg::CFG_AFFINE_RED] = data;
        default: ;
      endcase
    endfunction

    function byte_t repack_channel(int c, byte_t b);
      logic [31:0]  aff;
      longint       scale, bias, t, num, one;
      int unsigned  m, code;
      aff   = cfg.affine[c];
      scale = longint'($signed(aff[31:16]));
      bias  = longint'($signed(aff[15:0]));
      if (!cfg.present[c]) return cfg.fill[8*c +: 8];
      if (aff == tcr_pkg::AFFINE_IDENTITY) return b;
      if (cfg.srgb && c != tcr_pkg::ALPHA_CHAN) begin
        // Affine in linear space, then count the encode thresholds reached.
        one = longint'(1) << (tcr_pkg::LIN_FRAC_BITS + tcr_pkg::AFF_FRAC_BITS);
        t   = longint'(decode_lut[b]) * scale
              + bias * (longint'(1) << tcr_pkg::LIN_FRAC_BITS);
        if (t <= 0) begin
          m = 0;
        end else if (t >= one) begin
          m = 1 << tcr_pkg::LIN_FRAC_BITS;
        end else begin
          m = int'((t + 2048) >>> tcr_pkg::AFF_FRAC_BITS);
        end
        code = 0;
        for (int k = 0; k < 255; k++) begin
          if (thresh_lut[k] <= m) code++;
        end
        return byte_t'(code);
      end
      // Encoded space: units of 1/(255*4096).
      num = longint'(b) * scale + 255 * bias;
      if (num <= 0) return 8'd0;
      if (num >= 255 * 4096) return 8'd255;
      return byte_t'((num + 2048) >>> tcr_pkg::AFF_FRAC_BITS);
    endfunction

    function void note_source(texel_t src);
      texel_t res;
      for (int c = 0; c < tcr_pkg::NUM_CHAN; c++) begin
        res[c] = repack_channel(c, src[c]);
      end
      pending = {pending, res};
    endfunction

    function void check_texel(texel_t got);
      texel_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: texel %h arrived with nothing pending", $time, got);
        end
        return;
      end
      want = pending.pop_front();
      checked++;
      for (int c = 0; c < tcr_pkg::NUM_CHAN; c++) begin
        if (got[c] !== want[c]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, chan_name[c],
                     want[c], got[c]);
          end
        end
      end
    endfunction

    function void report_leftovers();
      if (pending.size() != 0) begin
        mismatches += pending.size();
        $display("%0d texels never arrived", pending.size());
      end
    endfunction
  endclass

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  byte_t       in_src_red   = '0;
  byte_t       in_src_green = '0;
  byte_t       in_src_blue  = '0;
  byte_t       in_src_alpha = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  byte_t       out_red;
  byte_t       out_green;
  byte_t       out_blue;
  byte_t       out_alpha;
  logic        cfg_we       = 1'b0;
  logic [IDX_W-1:0]               cfg_index = '0;
  logic [tcr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  int          idle_pct      = 0;
  int          stall_pct     = 0;
  int          settings      = 0;
  int          srgb_settings = 0;

  texel_scoreboard sb = new();

  texel_channel_repack u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_src_red   (in_src_red),
    .in_src_green (in_src_green),
    .in_src_blue  (in_src_blue),
    .in_src_alpha (in_src_alpha),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_alpha    (out_alpha),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Inputs are noted before outputs are checked on the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_source({in_src_alpha, in_src_blue, in_src_green, in_src_red});
      end
      if (out_valid && !out_stall) begin
        sb.check_texel({out_alpha, out_blue, out_green, out_red});
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic send_texel(input texel_t src);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    {in_src_alpha, in_src_blue, in_src_green, in_src_red} <= src;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the sender until every pending texel has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    sb.write_reg(idx, data);
  endtask

  // Narrow registers get random upper bits, which the block must ignore.
  task automatic apply_cfg(input repack_cfg_t c, input bit poke_unused);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(tcr_pkg::CFG_CHANNEL_PRESENT, {junk[31:4], c.present});
    write_reg(tcr_pkg::CFG_FILL_BYTES, c.fill);
    junk = $urandom();
    write_reg(tcr_pkg::CFG_SRGB_MODE, {junk[31:1], c.srgb});
    for (int ch = 0; ch < tcr_pkg::NUM_CHAN; ch++) begin
      write_reg(IDX_W'(tcr_pkg::CFG_AFFINE_RED + ch), c.affine[ch]);
    end
    if (poke_unused) begin
      write_reg(CFG_IDX_UNUSED, $urandom());
    end
    cfg_we <= 1'b0;
    settings++;
    if (c.srgb) srgb_settings++;
  endtask

  function automatic repack_cfg_t make_cfg(logic [3:0] present, logic [31:0] fill,
                                           logic srgb, logic [31:0] aff_r,
                                           logic [31:0] aff_g, logic [31:0] aff_b,
                                           logic [31:0] aff_a);
    repack_cfg_t c;
    c.present = present;
    c.fill    = fill;
    c.srgb    = srgb;
    c.affine  = {aff_a, aff_b, aff_g, aff_r};
    return c;
  endfunction

  function automatic logic [31:0] random_affine();
    logic [15:0] scale;
    logic [15:0] bias;
    logic [15:0] corner [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h1000};
    case ($urandom_range(0, 5))
      0: return tcr_pkg::AFFINE_IDENTITY;
      1: return $urandom();
      2: begin
        scale = 16'h1000 + 16'($urandom_range(0, 4095)) - 16'h0800;
        bias  = 16'($urandom_range(0, 2047)) - 16'h0400;
      end
      3: begin
        scale = 16'($urandom_range(0, 8191));
        bias  = '0;
      end
      4: begin
        scale = 16'h1000;
        bias  = 16'($urandom_range(0, 1023)) - 16'h0200;
      end
      default: begin
        scale = corner[$urandom_range(0, 3)];
        bias  = corner[$urandom_range(0, 3)];
      end
    endcase
    return {scale, bias};
  endfunction

  function automatic repack_cfg_t random_cfg();
    repack_cfg_t c;
    c.present = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'hF;
    c.fill    = $urandom();
    c.srgb    = 1'($urandom_range(0, 1));
    for (int ch = 0; ch < tcr_pkg::NUM_CHAN; ch++) begin
      c.affine[ch] = random_affine();
    end
    return c;
  endfunction

  function automatic texel_t random_texel();
    texel_t t;
    for (int c = 0; c < tcr_pkg::NUM_CHAN; c++) begin
      case ($urandom_range(0, 7))
        0:       t[c] = 8'h00;
        1:       t[c] = 8'hFF;
        default: t[c] = byte_t'($urandom_range(0, 255));
      endcase
    end
    return t;
  endfunction

  initial begin
    int n_rand;
    int run_len;
    idle_pct  = 31;
    stall_pct = 75;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // After reset every channel is absent and the fill is zero.
    send_texel(32'hFFFF_FFFF);
    send_texel(32'h0000_0000);
    drain();
    apply_cfg(make_cfg(4'h0, 32'hFFFF_FFFF, 1'b1, 32'h0800_0000, 32'h7FFF_7FFF,
                       32'h8000_8000, 32'h0000_0000), 1'b0);
    send_texel(32'h1234_5678);
    drain();
    // Identity everywhere: bytes pass straight through.
    apply_cfg(make_cfg(4'hF, 32'h0000_0000, 1'b0, tcr_pkg::AFFINE_IDENTITY,
                       tcr_pkg::AFFINE_IDENTITY, tcr_pkg::AFFINE_IDENTITY,
                       tcr_pkg::AFFINE_IDENTITY), 1'b0);
    send_texel(32'h0000_0000);
    send_texel(32'hFFFF_FFFF);
    send_texel(32'h807F_01FE);
    drain();
    // sRGB mode with an identity green, a bias on blue and alpha on the encoded path.
    apply_cfg(make_cfg(4'hF, 32'h0000_0000, 1'b1, 32'h0800_0000, tcr_pkg::AFFINE_IDENTITY,
                       32'h1000_0800, 32'h0800_0000), 1'b0);
    send_texel(32'h0000_0000);
    send_texel(32'hFFFF_FFFF);
    send_texel(32'h4080_C010);
    send_texel(32'h0301_0203);
    drain();
    // Extreme scales and biases saturate at both ends, in both modes.
    apply_cfg(make_cfg(4'hF, 32'h0000_0000, 1'b0, 32'h7FFF_7FFF, 32'h8000_8000,
                       32'h7FFF_8000, 32'h8000_7FFF), 1'b0);
    send_texel(32'h0000_0000);
    send_texel(32'hFFFF_FFFF);
    send_texel(32'h8080_8080);
    drain();
    apply_cfg(make_cfg(4'hF, 32'h0000_0000, 1'b1, 32'h7FFF_7FFF, 32'h8000_8000,
                       32'h7FFF_8000, 32'h8000_7FFF), 1'b0);
    send_texel(32'h0000_0000);
    send_texel(32'hFFFF_FFFF);
    send_texel(32'h8080_8080);
    drain();
    // Absent channels take their fill; a write past the last register changes nothing.
    apply_cfg(make_cfg(4'hA, 32'h5AC3_0FF0, 1'b1, 32'h0C00_0100, 32'hF000_1000,
                       32'h1400_FF00, 32'h0000_0800), 1'b1);
    send_texel(32'h33CC_55AA);
    send_texel(32'hFF00_FF00);

    n_rand = 0;
    while (n_rand < NUM_RANDOM) begin
      if (n_rand < NUM_RANDOM / 3) begin
        idle_pct  = 31;
        stall_pct = 75;
      end else if (n_rand < 2 * NUM_RANDOM / 3) begin
        idle_pct  = 75;
        stall_pct = 31;
      end else begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      drain();
      apply_cfg(random_cfg(), $urandom_range(0, 9) == 0);
      run_len = $urandom_range(16, 48);
      repeat (run_len) begin
        if ($urandom_range(0, 149) == 0) drain();
        send_texel(random_texel());
        n_rand++;
      end
    end

    drain();
    repeat (SETTLE) @(negedge clk);
    sb.report_leftovers();
    $display("Checked %0d texels across %0d register settings (%0d in sRGB mode),",
             sb.checked, settings, srgb_settings);
    $display("with sender gaps and receiver stalls in turn and then a full-rate stretch.");
    if (sb.mismatches == 0) begin
      $display("texel_channel_repack_test: PASS");
    end else begin
      $display("%0d mismatches in total", sb.mismatches);
      $display("texel_channel_repack_test: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d texels pending", sb.pending.size());
    $display("texel_channel_repack_test: FAIL");
    $finish;
  end

endmodule

@@ texel_channel_repack.f @@
design/tcr_pkg.sv
design/tcr_pipe_ctrl.sv
design/tcr_lane.sv
design/tcr_merge.sv
design/texel_channel_repack.sv
sim/texel_channel_repack_test.sv
